[sv/blp_pkg.sv]
package blp_pkg;

   localparam int PRICE_W = 32;
   localparam int COEF_W = 32;
   localparam int STEPS_CSR_W = 9;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [PRICE_W-1:0] PRICE_MAX = '1;
   localparam logic [COEF_W-1:0] ONE_Q31 = 32'h8000_0000;
   localparam logic [COEF_W-1:0] ONE_Q30 = 32'h4000_0000;

   // register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_UP_FACTOR = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DOWN_FACTOR = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_UP_PROBABILITY = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISCOUNT_FACTOR = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEPS_IN_USE = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_OPTION_KIND = 3'd5;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_BUILD,
      CELL_PAYOFF,
      CELL_MIX,
      CELL_DISC
   } cell_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BUILD,
      ST_PAYOFF,
      ST_MIX,
      ST_DISC,
      ST_FINISH
   } state_type;

   typedef struct packed {
      cell_op_type op;
      logic        put;
   } cell_cmd_type;

   typedef struct packed {
      logic [COEF_W-1:0]  up;
      logic [COEF_W-1:0]  down;
      logic [COEF_W-1:0]  prob;
      logic [COEF_W-1:0]  disc;
      logic [PRICE_W-1:0] strike;
   } cell_coef_type;

endpackage

[sv/binomial_lattice_european_pricer.sv]
// European option pricer on a binomial lattice of up to MAX_STEPS time steps. Each request
// transaction carries spot and strike; the result transaction carries the root value and a
// flag that is set when any price built in the lattice saturated. The lattice is a row of MAX_STEPS+1 cells,
// each holding one node and one 33x33 multiplier. With N the clamped steps_in_use, a request
// builds the leaves one lattice level per cycle, applies the payoff, then folds N levels,
// each with a mix step and then a discount step, because every cell's single multiplier
// does the probability mix and then the discount; a finish step moves the root into the
// output register once that register is free. A new request is taken once the previous
// result sits in the output register. The user must write configuration through the csr_
// port only while no request is in flight; the block itself does not enforce this.
module binomial_lattice_european_pricer #(
   parameter int MAX_STEPS = 256
) (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_write_en,
   input  logic [blp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [blp_pkg::CSR_DATA_W-1:0]  csr_wdata,
   // requests
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,    // spot_price [31:0], strike_price [63:32]
   // results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // option_value [31:0]
   output logic [0:0]  rsp_tuser     // saturated [0]
);
   import blp_pkg::*;

   localparam int NC = MAX_STEPS + 1;
   localparam int LW = $clog2(MAX_STEPS + 1);

   logic [COEF_W-1:0]  up_ff, down_ff, prob_ff, disc_ff;
   logic [LW-1:0]      steps_ff;
   logic               put_ff;
   logic [STEPS_CSR_W-1:0] steps_raw;
   logic [LW-1:0]      steps_clamped;

   logic [PRICE_W-1:0] strike_ff, strike_in;
   state_type          state_ff, state_in;
   logic [LW-1:0]      level_ff, level_in;
   cell_cmd_type       cmd;
   cell_coef_type      coef;
   logic               req_accept;
   logic               capture;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [PRICE_W-1:0] rsp_value_ff, rsp_value_in;
   logic               rsp_sat_ff, rsp_sat_in;

   logic [PRICE_W-1:0] cell_value [NC];
   logic               cell_flag [NC];

   // configuration registers; probability, discount and steps are clamped on write
   assign steps_raw = csr_wdata[STEPS_CSR_W-1:0];

   always_comb begin
      priority if (steps_raw == '0) begin
         steps_clamped = LW'(1);
      end else if (int'(steps_raw) > MAX_STEPS) begin
         steps_clamped = LW'(MAX_STEPS);
      end else begin
         steps_clamped = LW'(steps_raw);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         up_ff <= ONE_Q30;
         down_ff <= ONE_Q30;
         prob_ff <= ONE_Q30;
         disc_ff <= ONE_Q31;
         steps_ff <= LW'(1);
         put_ff <= 1'b0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_UP_FACTOR: up_ff <= csr_wdata;
            CSR_DOWN_FACTOR: down_ff <= csr_wdata;
            CSR_UP_PROBABILITY: prob_ff <= (csr_wdata > ONE_Q31) ? ONE_Q31 : csr_wdata;
            CSR_DISCOUNT_FACTOR: disc_ff <= (csr_wdata > ONE_Q31) ? ONE_Q31 : csr_wdata;
            CSR_STEPS_IN_USE: steps_ff <= steps_clamped;
            CSR_OPTION_KIND: put_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   assign req_tready = state_ff == ST_IDLE;
   assign req_accept = req_tvalid && req_tready;
   assign capture = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_tready);

   // sequencer: next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_BUILD;
            end
         end
         ST_BUILD: begin
            if (level_ff == steps_ff - LW'(1)) begin
               state_in = ST_PAYOFF;
            end
         end
         ST_PAYOFF: state_in = ST_MIX;
         ST_MIX: state_in = ST_DISC;
         ST_DISC: begin
            state_in = (level_ff == LW'(1)) ? ST_FINISH : ST_MIX;
         end
         ST_FINISH: begin
            if (capture) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer: outputs
   always_comb begin
      cmd.op = CELL_HOLD;
      cmd.put = put_ff;
      level_in = level_ff;
      strike_in = strike_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cmd.op = CELL_LOAD;
               level_in = '0;
               strike_in = req_tdata[63:32];
            end
         end
         ST_BUILD: begin
            cmd.op = CELL_BUILD;
            level_in = (level_ff == steps_ff - LW'(1)) ? steps_ff : level_ff + LW'(1);
         end
         ST_PAYOFF: cmd.op = CELL_PAYOFF;
         ST_MIX: cmd.op = CELL_MIX;
         ST_DISC: begin
            cmd.op = CELL_DISC;
            level_in = level_ff - LW'(1);
         end
         ST_FINISH: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      strike_ff <= strike_in;
      level_ff <= level_in;
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign coef.up = up_ff;
   assign coef.down = down_ff;
   assign coef.prob = prob_ff;
   assign coef.disc = disc_ff;
   assign coef.strike = strike_ff;

   for (genvar i = 0; i < NC; i++) begin : g_cell
      logic [PRICE_W-1:0] left_value;
      logic [PRICE_W-1:0] right_value;
      logic               right_flag;

      if (i == 0) begin : g_first
         assign left_value = req_tdata[31:0];
      end else begin : g_inner_left
         assign left_value = cell_value[i-1];
      end

      if (i == NC - 1) begin : g_last
         assign right_value = '0;
         assign right_flag = 1'b0;
      end else begin : g_inner_right
         assign right_value = cell_value[i+1];
         assign right_flag = cell_flag[i+1];
      end

      blp_cell #(
         .IDX(i),
         .LW (LW)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .coef       (coef),
         .level      (level_ff),
         .left_value (left_value),
         .right_value(right_value),
         .right_flag (right_flag),
         .value      (cell_value[i]),
         .flag       (cell_flag[i])
      );
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_value_in = rsp_value_ff;
      rsp_sat_in = rsp_sat_ff;
      if (capture) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = cell_value[0];
         rsp_sat_in = cell_flag[0];
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_sat_ff <= rsp_sat_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_value_ff;
   assign rsp_tuser = rsp_sat_ff;

endmodule

[sv/blp_cell.sv]
module blp_cell #(
   parameter int IDX = 0,
   parameter int LW = 9
) (
   input  logic                   clock,
   input  logic                   reset,
   input  blp_pkg::cell_cmd_type  cmd,
   input  blp_pkg::cell_coef_type coef,
   input  logic [LW-1:0]          level,
   input  logic [31:0]            left_value,
   input  logic [31:0]            right_value,
   input  logic                   right_flag,
   output logic [31:0]            value,
   output logic                   flag
);
   import blp_pkg::*;

   logic [PRICE_W-1:0]   value_ff, value_in;
   logic                 flag_ff, flag_in;
   logic signed [32:0]   mul_a;
   logic [COEF_W-1:0]    mul_b;
   logic signed [65:0]   prod;
   logic                 sat;
   logic [PRICE_W-1:0]   scaled;
   logic                 below_level;
   logic                 at_top;

   assign below_level = IDX < int'(level);
   assign at_top = IDX == int'(level) + 1;

   // one shared multiplier per cell, operands picked by the current phase
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.op)
         CELL_BUILD: begin
            if (IDX <= int'(level)) begin
               mul_a = $signed({1'b0, value_ff});
               mul_b = coef.down;
            end else begin
               mul_a = $signed({1'b0, left_value});
               mul_b = coef.up;
            end
         end
         // q*lower + p*upper == 2^31*lower + p*(upper - lower)
         CELL_MIX: begin
            mul_a = $signed({1'b0, right_value}) - $signed({1'b0, value_ff});
            mul_b = coef.prob;
         end
         CELL_DISC: begin
            mul_a = $signed({1'b0, value_ff});
            mul_b = coef.disc;
         end
         default: begin
         end
      endcase
   end

   assign prod = mul_a * $signed({1'b0, mul_b});
   assign sat = |prod[63:62];
   assign scaled = sat ? PRICE_MAX : prod[61:30];

   always_comb begin
      value_in = value_ff;
      flag_in = flag_ff;
      unique case (cmd.op)
         CELL_HOLD: begin
         end
         CELL_LOAD: begin
            if (IDX == 0) begin
               value_in = left_value;
            end
            flag_in = 1'b0;
         end
         CELL_BUILD: begin
            if (IDX <= int'(level) || at_top) begin
               value_in = scaled;
               flag_in = flag_ff | sat;
            end
         end
         CELL_PAYOFF: begin
            if (!cmd.put) begin
               value_in = (value_ff > coef.strike) ? value_ff - coef.strike : '0;
            end else begin
               value_in = (coef.strike > value_ff) ? coef.strike - value_ff : '0;
            end
         end
         CELL_MIX: begin
            // flags drift one cell toward the root per fold level
            flag_in = flag_ff | right_flag;
            if (below_level) begin
               value_in = value_ff + prod[62:31];
            end
         end
         CELL_DISC: begin
            if (below_level) begin
               value_in = prod[62:31];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         flag_ff <= 1'b0;
      end else begin
         flag_ff <= flag_in;
      end
   end

   assign value = value_ff;
   assign flag = flag_ff;

endmodule

[tb/tb_binomial_lattice_european_pricer.sv]
`timescale 1ns / 100ps

module tb_binomial_lattice_european_pricer;
   import blp_pkg::*;

   localparam int LATTICE_STEPS = 256;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int HOLD_CYCLES = 400;

   // indexes that map to no register
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_7 = 3'd7;

   localparam logic [31:0] KIND_CALL = 32'd0;
   localparam logic [31:0] KIND_PUT = 32'd1;

   typedef struct packed {
      logic [31:0] spot;
      logic [31:0] strike;
   } quote_type;

   typedef struct packed {
      logic [31:0] value;
      logic        saturated;
   } option_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;    // spot_price [31:0], strike_price [63:32]

   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // option_value [31:0]
   logic [0:0]  rsp_tuser;         // saturated [0]

   // shadow copy of the configuration registers
   logic [31:0] cfg_up = ONE_Q30;
   logic [31:0] cfg_down = ONE_Q30;
   logic [31:0] cfg_prob = ONE_Q30;
   logic [31:0] cfg_discount = ONE_Q31;
   logic [8:0]  cfg_steps = 9'd1;
   logic        cfg_put = 1'b0;

   quote_type         quote_q[$];
   option_result_type expected_prices[$];
   int             quotes_queued = 0;
   int             quotes_priced = 0;
   int             mismatches = 0;
   int             cycle_count = 0;

   bit steady_send = 1'b0;
   bit steady_recv = 1'b0;
   bit hold_request = 1'b0;
   bit hold_used = 1'b0;
   int hold_left = 0;

   binomial_lattice_european_pricer #(
      .MAX_STEPS(LATTICE_STEPS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // price times Q2.30 factor, bit 32 flags saturation
   function automatic logic [32:0] move_price(input logic [31:0] price,
                                              input logic [31:0] factor);
      logic [63:0] prod;
      prod = (64'(price) * 64'(factor)) >> 30;
      return (prod[63:32] != 0) ? {1'b1, PRICE_MAX} : {1'b0, prod[31:0]};
   endfunction

   function automatic option_result_type price_european(input logic [31:0] spot,
                                                        input logic [31:0] strike);
      logic [31:0] node [0:LATTICE_STEPS];
      logic [32:0] moved;
      logic [31:0] top, p_up, p_down, disc;
      logic [63:0] mix, value;
      int n, k, j;
      option_result_type res;
      res.saturated = 1'b0;
      n = int'(cfg_steps);
      if (n < 1) n = 1;
      if (n > LATTICE_STEPS) n = LATTICE_STEPS;
      p_up = (cfg_prob > ONE_Q31) ? ONE_Q31 : cfg_prob;
      p_down = ONE_Q31 - p_up;
      disc = (cfg_discount > ONE_Q31) ? ONE_Q31 : cfg_discount;

      node[0] = spot;
      for (k = 0; k < n; k++) begin
         moved = move_price(node[k], cfg_up);
         res.saturated |= moved[32];
         top = moved[31:0];
         for (j = 0; j <= k; j++) begin
            moved = move_price(node[j], cfg_down);
            res.saturated |= moved[32];
            node[j] = moved[31:0];
         end
         node[k+1] = top;
      end

      for (j = 0; j <= n; j++) begin
         if (cfg_put) node[j] = (strike > node[j]) ? strike - node[j] : 32'd0;
         else node[j] = (node[j] > strike) ? node[j] - strike : 32'd0;
      end

      for (k = n; k > 0; k--) begin
         for (j = 0; j < k; j++) begin
            mix = (64'(p_down) * 64'(node[j]) + 64'(p_up) * 64'(node[j+1])) >> 31;
            value = (mix * 64'(disc)) >> 31;
            node[j] = value[31:0];
         end
      end
      res.value = node[0];
      return res;
   endfunction

   function automatic quote_type random_quote();
      quote_type qt;
      int unsigned whole;
      if ($urandom_range(3) == 0) begin
         qt.spot = $urandom;
         qt.strike = $urandom;
      end else begin
         // prices in a plausible range with strike near spot
         whole = $urandom_range(400, 50);
         qt.spot = {16'(whole), 16'($urandom)};
         qt.strike = {16'(whole + $urandom_range(80) - 40), 16'($urandom)};
      end
      return qt;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      mismatches++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index, input logic [31:0] data);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      case (index)
         CSR_UP_FACTOR: cfg_up = data;
         CSR_DOWN_FACTOR: cfg_down = data;
         CSR_UP_PROBABILITY: cfg_prob = data;
         CSR_DISCOUNT_FACTOR: cfg_discount = data;
         CSR_STEPS_IN_USE: cfg_steps = data[8:0];
         CSR_OPTION_KIND: cfg_put = data[0];
         default: ;
      endcase
   endtask

   task automatic close_csr();
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic apply_setup(input logic [31:0] up, input logic [31:0] down,
                              input logic [31:0] prob, input logic [31:0] discount,
                              input logic [31:0] steps, input logic [31:0] kind);
      write_csr(CSR_UP_FACTOR, up);
      write_csr(CSR_DOWN_FACTOR, down);
      write_csr(CSR_UP_PROBABILITY, prob);
      write_csr(CSR_DISCOUNT_FACTOR, discount);
      write_csr(CSR_STEPS_IN_USE, steps);
      write_csr(CSR_OPTION_KIND, kind);
      close_csr();
   endtask

   task automatic pick_setup(input int steps_cap);
      logic [31:0] up, down, prob, discount;
      if ($urandom_range(3) == 0) begin
         up = $urandom;
         down = $urandom;
         prob = $urandom;
         discount = $urandom;
      end else begin
         up = ONE_Q30 + $urandom_range(32'h0400_0000);
         down = ONE_Q30 - $urandom_range(32'h0400_0000);
         prob = $urandom_range(32'h5000_0000, 32'h3000_0000);
         discount = ONE_Q31 - $urandom_range(32'h0010_0000);
      end
      apply_setup(up, down, prob, discount, $urandom_range(steps_cap, 1),
                  $urandom_range(1) ? KIND_PUT : KIND_CALL);
   endtask

   task automatic add_quote(input logic [31:0] spot, input logic [31:0] strike);
      quote_type qt;
      qt.spot = spot;
      qt.strike = strike;
      quote_q.insert(quote_q.size(), qt);
      quotes_queued++;
   endtask

   task automatic queue_quotes(input int count);
      quote_type qt;
      @(negedge clock);
      repeat (count) begin
         qt = random_quote();
         add_quote(qt.spot, qt.strike);
      end
   endtask

   // every quote yields a result, so the block is idle once all are back
   task automatic settle();
      @(negedge clock);
      while (quotes_priced != quotes_queued || expected_prices.size() != 0)
         @(negedge clock);
   endtask

   always @(posedge clock) begin : quote_driver
      quote_type next_quote;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_prices.insert(expected_prices.size(),
                                   price_european(req_tdata[31:0], req_tdata[63:32]));
            quotes_priced++;
         end
         if (!req_tvalid || req_tready) begin
            if (quote_q.size() != 0 && (steady_send || $urandom_range(99) >= 27)) begin
               next_quote = quote_q.pop_front();
               req_tdata <= {next_quote.strike, next_quote.spot};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : result_monitor
      option_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_prices.size() == 0) begin
               report_mismatch("unexpected transaction, option_value", 32'h0, rsp_tdata);
            end else begin
               want = expected_prices.pop_front();
               if (rsp_tdata !== want.value)
                  report_mismatch("option_value", want.value, rsp_tdata);
               if (rsp_tuser[0] !== want.saturated)
                  report_mismatch("saturated", 32'(want.saturated), 32'(rsp_tuser[0]));
            end
         end
         if (hold_request && !hold_used) begin
            hold_left = HOLD_CYCLES;
            hold_used = 1'b1;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady_recv || ($urandom_range(99) >= 27);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset configuration: one step, flat factors, call
      @(negedge clock);
      add_quote(32'h0, 32'h0);
      add_quote(PRICE_MAX, 32'h0);
      add_quote(32'h0064_0000, 32'h0050_0000);
      settle();

      // largest factors saturate; probability and discount above one get clamped
      apply_setup(PRICE_MAX, PRICE_MAX, PRICE_MAX, PRICE_MAX, 32'd3, KIND_CALL);
      @(negedge clock);
      add_quote(PRICE_MAX, 32'h0);
      add_quote(32'h0001_0000, 32'h0000_8000);
      add_quote(32'h0, PRICE_MAX);
      settle();

      // all zero, zero steps taken as one
      apply_setup(32'h0, 32'h0, 32'h0, 32'h0, 32'd0, KIND_PUT);
      @(negedge clock);
      add_quote(32'h0064_0000, 32'h00C8_0000);
      add_quote(PRICE_MAX, PRICE_MAX);
      settle();

      // deepest lattice, probability and discount exactly one
      apply_setup(ONE_Q30 + 32'h0080_0000, ONE_Q30 - 32'h0080_0000, ONE_Q31, ONE_Q31,
                  32'd256, KIND_PUT);
      @(negedge clock);
      add_quote(32'h0064_0000, 32'h0068_0000);
      add_quote(32'h00C8_8000, 32'h0096_0000);
      settle();

      // steps above the maximum, upper data bits ignored, spare indexes ignored
      apply_setup(32'h4100_0000, 32'h3F00_0000, 32'h4000_0000, 32'h7FF0_0000,
                  32'hFFFF_FFFF, 32'hFFFF_FFFE);
      write_csr(CSR_SPARE_6, PRICE_MAX);
      write_csr(CSR_SPARE_7, 32'h0);
      close_csr();
      @(negedge clock);
      add_quote(32'h0064_0000, 32'h0060_0000);
      settle();

      apply_setup(ONE_Q30, ONE_Q30, ONE_Q31, 32'h7FFF_FFFF, 32'hFFFF_FE02, KIND_CALL);
      @(negedge clock);
      add_quote(PRICE_MAX, 32'h1);
      add_quote(32'h8000_0000, 32'h7FFF_FFFF);
      settle();

      // a few full-depth quotes with gentle moves
      apply_setup(ONE_Q30 + 32'h0020_0000, ONE_Q30 - 32'h0020_0000, 32'h4080_0000,
                  ONE_Q31 - 32'h0000_4000, 32'd256, $urandom_range(1) ? KIND_PUT : KIND_CALL);
      queue_quotes(10);
      settle();

      for (int phase = 0; phase < 24; phase++) begin
         pick_setup((phase % 6 == 5) ? 64 : 16);
         queue_quotes(40);
         settle();
      end

      // receiver holds off while the sender keeps offering
      pick_setup(2);
      steady_send = 1'b1;
      hold_request = 1'b1;
      queue_quotes(60);
      settle();
      steady_send = 1'b0;

      // no idling on either side
      pick_setup(8);
      steady_send = 1'b1;
      steady_recv = 1'b1;
      queue_quotes(60);
      settle();
      steady_send = 1'b0;
      steady_recv = 1'b0;

      repeat (3 * LATTICE_STEPS + 3) @(posedge clock);
      if (expected_prices.size() != 0) mismatches++;
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

[files.f]
sv/blp_pkg.sv
sv/blp_cell.sv
sv/binomial_lattice_european_pricer.sv
tb/tb_binomial_lattice_european_pricer.sv
